// ===== rtl/core/k_way_sorted_merge_defines.svh =====
// Assertion macros shared by the k-way sorted merge RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef K_WAY_SORTED_MERGE_DEFINES_SVH
`define K_WAY_SORTED_MERGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KWM_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kwm assertion failed");

// Next-cycle implication, disabled while reset is high.
`define KWM_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kwm assertion failed");

`endif

// ===== rtl/core/kwm_pkg.sv =====
// Package for the k-way sorted merge: field widths, operation and status codes,
// controller state type and the result record. Depends on nothing.
package kwm_pkg;

   localparam int DEF_NUM_LISTS  = 8;
   localparam int DEF_LIST_DEPTH = 256;

   localparam int FUNC_W     = 2;
   localparam int LIST_IDX_W = 3;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_SCAN,
      ST_WRBACK,
      ST_DONE
   } kwm_state_type;

   typedef struct packed {
      logic [VALUE_W-1:0]    value;
      logic [LIST_IDX_W-1:0] src;
      logic [STATUS_W-1:0]   status;
   } kwm_rsp_type;

endpackage

// ===== rtl/core/k_way_sorted_merge.sv =====
// K-way sorted merge of signed 32-bit lists.
//
// Request channel (req_valid / req_stall): one beat carries req_func,
// req_list_index and req_value. Clear empties every list, append adds
// req_value at the tail of list req_list_index, pop returns the smallest
// current head (lowest list index on ties) and advances that list.
// Response channel (rsp_valid / rsp_stall): exactly one beat per request,
// with rsp_merged_value, rsp_source_list and rsp_status (0 ok, 1 append
// dropped, 2 pop found every list empty).
// A pop scans the per-list state store, one list a cycle, through the registered
// reads of the state and element memories.
// One request is in flight at a time; a finished response sits in an output
// register, so a new request is taken while the receiver stalls, but the next
// response waits until that register is free.
// Reset (synchronous, active high) empties every list at once through valid
// bits; the element store is not cleared.
module k_way_sorted_merge import kwm_pkg::*; #(
   parameter int NUM_LISTS  = DEF_NUM_LISTS,
   parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [LIST_IDX_W-1:0] req_list_index,
   input  logic [VALUE_W-1:0]    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_W-1:0]    rsp_merged_value,
   output logic [LIST_IDX_W-1:0] rsp_source_list,
   output logic [STATUS_W-1:0]   rsp_status
);

   localparam int IW = $clog2(NUM_LISTS);
   localparam int LW = $clog2(LIST_DEPTH + 1);
   localparam int DEPTH = NUM_LISTS * LIST_DEPTH;
   localparam int AW = $clog2(DEPTH);

   logic               st_clear;
   logic               st_wr_en;
   logic [IW-1:0]      st_wr_addr;
   logic [2*LW-1:0]    st_wr_data;
   logic               st_rd_en;
   logic [IW-1:0]      st_rd_addr;
   logic [2*LW-1:0]    st_rd_data;
   logic               el_wr_en;
   logic [AW-1:0]      el_wr_addr;
   logic [VALUE_W-1:0] el_wr_data;
   logic               el_rd_en;
   logic [AW-1:0]      el_rd_addr;
   logic [VALUE_W-1:0] el_rd_data;

   kwm_ctrl #(
      .NUM_LISTS  (NUM_LISTS),
      .LIST_DEPTH (LIST_DEPTH),
      .IW         (IW),
      .LW         (LW),
      .AW         (AW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_list_index   (req_list_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged_value (rsp_merged_value),
      .rsp_source_list  (rsp_source_list),
      .rsp_status       (rsp_status),
      .st_clear         (st_clear),
      .st_wr_en         (st_wr_en),
      .st_wr_addr       (st_wr_addr),
      .st_wr_data       (st_wr_data),
      .st_rd_en         (st_rd_en),
      .st_rd_addr       (st_rd_addr),
      .st_rd_data       (st_rd_data),
      .el_wr_en         (el_wr_en),
      .el_wr_addr       (el_wr_addr),
      .el_wr_data       (el_wr_data),
      .el_rd_en         (el_rd_en),
      .el_rd_addr       (el_rd_addr),
      .el_rd_data       (el_rd_data)
   );

   kwm_state_mem #(
      .NUM_LISTS (NUM_LISTS),
      .IW        (IW),
      .SW        (2 * LW)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (st_clear),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   kwm_elem_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_elem_mem (
      .clock   (clock),
      .wr_en   (el_wr_en),
      .wr_addr (el_wr_addr),
      .wr_data (el_wr_data),
      .rd_en   (el_rd_en),
      .rd_addr (el_rd_addr),
      .rd_data (el_rd_data)
   );

endmodule

// ===== rtl/core/kwm_elem_mem.sv =====
// Element store: one write port, one registered read port.
// Depends on kwm_pkg for the value width.
module kwm_elem_mem import kwm_pkg::*; #(
   parameter int DEPTH = DEF_NUM_LISTS * DEF_LIST_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/kwm_state_mem.sv =====
// Per-list state store holding {length, read position}, with valid bits so that
// a clear empties every list at once. Depends on kwm_pkg.
module kwm_state_mem import kwm_pkg::*; #(
   parameter int NUM_LISTS = DEF_NUM_LISTS,
   parameter int IW        = $clog2(NUM_LISTS),
   parameter int SW        = 18
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  logic [SW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output logic [SW-1:0] rd_data
);

   localparam int ENTRIES = 1 << IW;

   logic [SW-1:0]      mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [SW-1:0]      rd_word_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

// ===== rtl/core/kwm_ctrl.sv =====
// Controller for the k-way sorted merge: sequences append, clear and the pop
// scan over the state and element stores, and holds the result register.
// Depends on kwm_pkg and k_way_sorted_merge_defines.svh.
`include "k_way_sorted_merge_defines.svh"
module kwm_ctrl import kwm_pkg::*; #(
   parameter int NUM_LISTS  = DEF_NUM_LISTS,
   parameter int LIST_DEPTH = DEF_LIST_DEPTH,
   parameter int IW         = $clog2(NUM_LISTS),
   parameter int LW         = $clog2(LIST_DEPTH + 1),
   parameter int AW         = $clog2(NUM_LISTS * LIST_DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [LIST_IDX_W-1:0] req_list_index,
   input  logic [VALUE_W-1:0]    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_W-1:0]    rsp_merged_value,
   output logic [LIST_IDX_W-1:0] rsp_source_list,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  st_clear,
   output logic                  st_wr_en,
   output logic [IW-1:0]         st_wr_addr,
   output logic [2*LW-1:0]       st_wr_data,
   output logic                  st_rd_en,
   output logic [IW-1:0]         st_rd_addr,
   input  logic [2*LW-1:0]       st_rd_data,
   output logic                  el_wr_en,
   output logic [AW-1:0]         el_wr_addr,
   output logic [VALUE_W-1:0]    el_wr_data,
   output logic                  el_rd_en,
   output logic [AW-1:0]         el_rd_addr,
   input  logic [VALUE_W-1:0]    el_rd_data
);

   localparam int CW = $clog2(NUM_LISTS + 1);

   kwm_state_type state_ff, state_in;

   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic               idx_ok_ff, idx_ok_in;
   logic [VALUE_W-1:0] value_ff, value_in;

   logic [CW-1:0]      scan_ff, scan_in;
   logic               s1_vld_ff, s1_vld_in;
   logic [IW-1:0]      s1_idx_ff, s1_idx_in;
   logic               s2_vld_ff, s2_vld_in;
   logic [IW-1:0]      s2_idx_ff, s2_idx_in;
   logic [LW-1:0]      s2_len_ff, s2_len_in;
   logic [LW-1:0]      s2_pos_ff, s2_pos_in;
   logic               found_ff, found_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic [VALUE_W-1:0] best_val_ff, best_val_in;
   logic [LW-1:0]      best_len_ff, best_len_in;
   logic [LW-1:0]      best_pos_ff, best_pos_in;

   kwm_rsp_type        res_ff, res_in;
   kwm_rsp_type        out_ff, out_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic [LW-1:0]      rd_len;
   logic [LW-1:0]      rd_pos;
   logic               avail;
   logic               scan_done;
   logic               out_free;

   assign accept    = req_valid && !req_stall;
   assign rd_len    = st_rd_data[2*LW-1:LW];
   assign rd_pos    = st_rd_data[LW-1:0];
   assign avail     = s1_vld_ff && (rd_pos < rd_len) && (32'(rd_pos) < LIST_DEPTH);
   assign scan_done = (32'(scan_ff) >= NUM_LISTS) && !s1_vld_ff && !s2_vld_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_APPEND) begin
                  state_in = ST_APPEND;
               end else if (req_func == FUNC_POP) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_APPEND: state_in = ST_DONE;
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_WRBACK;
            end
         end
         ST_WRBACK: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      func_in      = func_ff;
      idx_in       = idx_ff;
      idx_ok_in    = idx_ok_ff;
      value_in     = value_ff;
      scan_in      = scan_ff;
      s1_vld_in    = 1'b0;
      s1_idx_in    = s1_idx_ff;
      s2_vld_in    = 1'b0;
      s2_idx_in    = s2_idx_ff;
      s2_len_in    = s2_len_ff;
      s2_pos_in    = s2_pos_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      best_len_in  = best_len_ff;
      best_pos_in  = best_pos_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      st_clear     = 1'b0;
      st_wr_en     = 1'b0;
      st_wr_addr   = idx_ff;
      st_wr_data   = {rd_len + LW'(1), rd_pos};
      st_rd_en     = 1'b0;
      st_rd_addr   = IW'(req_list_index);
      el_wr_en     = 1'b0;
      el_wr_addr   = AW'(32'(idx_ff) * LIST_DEPTH + 32'(rd_len));
      el_wr_data   = value_ff;
      el_rd_en     = 1'b0;
      el_rd_addr   = AW'(32'(s1_idx_ff) * LIST_DEPTH + 32'(rd_pos));
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in   = req_func;
               idx_in    = IW'(req_list_index);
               idx_ok_in = (32'(req_list_index) < NUM_LISTS);
               value_in  = req_value;
               st_rd_en  = 1'b1;
               scan_in   = '0;
               found_in  = 1'b0;
               res_in    = '{value: '0, src: '0, status: STATUS_OK};
               if (req_func == FUNC_CLEAR) begin
                  st_clear = 1'b1;
               end
            end
         end
         ST_APPEND: begin
            if (idx_ok_ff && (32'(rd_len) < LIST_DEPTH)) begin
               el_wr_en = 1'b1;
               st_wr_en = 1'b1;
               res_in   = '{value: '0, src: '0, status: STATUS_OK};
            end else begin
               res_in   = '{value: '0, src: '0, status: STATUS_FULL};
            end
         end
         ST_SCAN: begin
            if (32'(scan_ff) < NUM_LISTS) begin
               st_rd_en   = 1'b1;
               st_rd_addr = scan_ff[IW-1:0];
               scan_in    = scan_ff + CW'(1);
               s1_vld_in  = 1'b1;
               s1_idx_in  = scan_ff[IW-1:0];
            end
            el_rd_en  = avail;
            s2_vld_in = avail;
            s2_idx_in = s1_idx_ff;
            s2_len_in = rd_len;
            s2_pos_in = rd_pos;
            if (s2_vld_ff && (!found_ff || ($signed(el_rd_data) < $signed(best_val_ff)))) begin
               found_in    = 1'b1;
               best_idx_in = s2_idx_ff;
               best_val_in = el_rd_data;
               best_len_in = s2_len_ff;
               best_pos_in = s2_pos_ff;
            end
         end
         ST_WRBACK: begin
            if (found_ff) begin
               st_wr_en   = 1'b1;
               st_wr_addr = best_idx_ff;
               st_wr_data = {best_len_ff, best_pos_ff + LW'(1)};
               res_in     = '{value: best_val_ff, src: LIST_IDX_W'(best_idx_ff),
                              status: STATUS_OK};
            end else begin
               res_in     = '{value: '0, src: '0, status: STATUS_EMPTY};
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         scan_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         found_ff     <= found_in;
         scan_ff      <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      idx_ff      <= idx_in;
      idx_ok_ff   <= idx_ok_in;
      value_ff    <= value_in;
      s1_idx_ff   <= s1_idx_in;
      s2_idx_ff   <= s2_idx_in;
      s2_len_ff   <= s2_len_in;
      s2_pos_ff   <= s2_pos_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      best_len_ff <= best_len_in;
      best_pos_ff <= best_pos_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = out_ff.value;
   assign rsp_source_list  = out_ff.src;
   assign rsp_status       = out_ff.status;

   `KWM_ASSERT_NXT(a_stall_after_accept, accept, req_stall)
   `KWM_ASSERT_IMP(a_elem_write_in_append, el_wr_en, state_ff == ST_APPEND)
   `KWM_ASSERT_IMP(a_append_func, state_ff == ST_APPEND, func_ff == FUNC_APPEND)
   `KWM_ASSERT_IMP(a_popped_head_live, (state_ff == ST_WRBACK) && found_ff,
                   best_pos_ff < best_len_ff)

endmodule

// ===== dv/tb_k_way_sorted_merge.sv =====
// Self-checking testbench for the k-way sorted merge: drives clear, append and pop
// beats, predicts every response with a behavioral merge model and checks it.
// Depends on kwm_pkg and the k_way_sorted_merge RTL.
`timescale 1ns / 100ps

module tb_k_way_sorted_merge import kwm_pkg::*;;

   localparam int NL = DEF_NUM_LISTS;
   localparam int LD = DEF_LIST_DEPTH;

   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]     func;
      logic [LIST_IDX_W-1:0] idx;
      logic [VALUE_W-1:0]    value;
   } req_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [FUNC_W-1:0] req_func = '0;
   logic [LIST_IDX_W-1:0] req_list_index = '0;
   logic [VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [VALUE_W-1:0] rsp_merged_value;
   logic [LIST_IDX_W-1:0] rsp_source_list;
   logic [STATUS_W-1:0] rsp_status;

   req_beat_type pending_reqs[$];
   kwm_rsp_type expected_rsps[$];
   logic signed [VALUE_W-1:0] list_data[NL][LD];
   int unsigned list_len[NL];
   int unsigned list_head[NL];
   int errors = 0;
   int n_pops = 0, n_empty = 0, n_full = 0;
   bit hold_rsp = 1'b0;
   bit pause_req = 1'b0;
   int req_gap = 0, rsp_gap = 0;

   k_way_sorted_merge dut (.*);

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Behavioral merge: updates the list state and returns the response.
   function automatic kwm_rsp_type merge_step(req_beat_type b);
      kwm_rsp_type r;
      int best;
      r = '0;
      best = -1;
      case (b.func)
         FUNC_CLEAR: begin
            for (int i = 0; i < NL; i++) begin
               list_len[i] = 0;
               list_head[i] = 0;
            end
         end
         FUNC_APPEND: begin
            if (b.idx >= NL || list_len[b.idx] >= LD) begin
               r.status = STATUS_FULL;
            end else begin
               list_data[b.idx][list_len[b.idx]] = b.value;
               list_len[b.idx]++;
            end
         end
         FUNC_POP: begin
            for (int i = 0; i < NL; i++) begin
               if (list_head[i] < list_len[i]) begin
                  if (best < 0 || list_data[i][list_head[i]] < list_data[best][list_head[best]])
                     best = i;
               end
            end
            if (best < 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.value = list_data[best][list_head[best]];
               r.src = best[LIST_IDX_W-1:0];
               list_head[best]++;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic void queue_req(logic [1:0] f, logic [2:0] i, logic [31:0] v);
      req_beat_type b;
      b.func = f;
      b.idx = i;
      b.value = v;
      pending_reqs = {pending_reqs, b};
   endfunction

   // Driver: predicts at the edge that accepts a beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps = {expected_rsps,
                             merge_step({req_func, req_list_index, req_value})};
            if (req_func == FUNC_POP) n_pops++;
         end
         if (req_valid && req_stall) begin
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (!pause_req && pending_reqs.size() > 0) begin
            req_beat_type b;
            b = pending_reqs.pop_front();
            req_func <= b.func;
            req_list_index <= b.idx;
            req_value <= b.value;
            req_valid <= 1'b1;
            req_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each accepted response beat and drives the stall.
   always @(posedge clock) begin
      kwm_rsp_type w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected beat", 32'(rsp_status), 32'd0);
            end else begin
               w = expected_rsps.pop_front();
               if (rsp_merged_value !== w.value)
                  report_mismatch("value", rsp_merged_value, w.value);
               if (rsp_source_list !== w.src)
                  report_mismatch("source", 32'(rsp_source_list), 32'(w.src));
               if (rsp_status !== w.status)
                  report_mismatch("status", 32'(rsp_status), 32'(w.status));
               if (w.status == STATUS_EMPTY) n_empty++;
               if (w.status == STATUS_FULL) n_full++;
            end
         end
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_gap <= pick_gap();
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (NL + 10) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h8000_0000;
      if (r == 1) return 32'h7fff_ffff;
      if (r < 5) return $urandom_range(0, 20) - 10;
      return $urandom();
   endfunction

   // Lists that are sorted or hold random values, then pops; some noise mixed in.
   function automatic void queue_merge_set(int per_list, bit sorted);
      int n;
      int cnt;
      logic signed [31:0] v;
      n = 0;
      queue_req(FUNC_CLEAR, 3'd0, $urandom());
      for (int l = 0; l < NL; l++) begin
         v = 32'sh8000_0000 + $urandom_range(0, 1000);
         cnt = $urandom_range(0, per_list);
         for (int k = 0; k < cnt; k++) begin
            v = sorted ? v + $urandom_range(0, 3) * $urandom_range(0, 40000000) : rand_value();
            queue_req(FUNC_APPEND, 3'(l), v);
            n++;
         end
      end
      for (int k = 0; k < n + 2; k++) begin
         if ($urandom_range(0, 15) == 0) queue_req(FUNC_APPEND, 3'($urandom()), rand_value());
         else if ($urandom_range(0, 30) == 0) queue_req(FUNC_NONE, 3'($urandom()), $urandom());
         queue_req(FUNC_POP, 3'($urandom()), $urandom());
      end
   endfunction

   initial begin
      int total;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pop, extremes, ties, unused code, append after exhaustion.
      queue_req(FUNC_POP, 3'd0, 32'd0);
      queue_req(FUNC_APPEND, 3'd7, 32'h7fff_ffff);
      queue_req(FUNC_APPEND, 3'd0, 32'h8000_0000);
      queue_req(FUNC_APPEND, 3'd3, 32'h0000_0005);
      queue_req(FUNC_APPEND, 3'd5, 32'h0000_0005);
      queue_req(FUNC_APPEND, 3'd0, 32'hffff_ffff);
      queue_req(FUNC_NONE, 3'b111, 32'hffff_ffff);
      repeat (6) queue_req(FUNC_POP, 3'b111, 32'hffff_ffff);
      queue_req(FUNC_APPEND, 3'd2, 32'h0000_0001);
      queue_req(FUNC_POP, 3'd0, 32'd0);
      queue_req(FUNC_APPEND, 3'd1, 32'h5555_5555);
      queue_req(FUNC_CLEAR, 3'd0, 32'd0);
      queue_req(FUNC_POP, 3'd0, 32'd0);
      wait_drained();

      // Fill one list to overflow, popping one before the extra appends to show pops free nothing.
      for (int k = 0; k < LD; k++) queue_req(FUNC_APPEND, 3'd4, 32'(k));
      queue_req(FUNC_POP, 3'd0, 32'd0);
      queue_req(FUNC_APPEND, 3'd4, 32'h1234_5678);
      queue_req(FUNC_APPEND, 3'd4, 32'h8000_0000);
      queue_req(FUNC_POP, 3'd0, 32'd0);
      queue_req(FUNC_CLEAR, 3'd0, 32'd0);

      // Long receiver hold-off while requests keep coming.
      for (int k = 0; k < 12; k++) queue_req(FUNC_APPEND, 3'($urandom()), rand_value());
      hold_rsp = 1'b1;
      repeat (200) @(posedge clock);
      hold_rsp = 1'b0;

      // Sender pauses until every response is back.
      pause_req = 1'b1;
      while (expected_rsps.size() > 0 || req_valid) @(posedge clock);
      pause_req = 1'b0;

      total = 0;
      while (total < 1600) begin
         total -= pending_reqs.size();
         queue_merge_set($urandom_range(0, 9) == 0 ? 12 : 4, $urandom_range(0, 4) != 0);
         total += pending_reqs.size();
         while (pending_reqs.size() > 40) @(posedge clock);
      end
      wait_drained();

      $display("Covered %0d pops (%0d empty) and %0d dropped appends over merge sets.",
               n_pops, n_empty, n_full);
      if (errors == 0) begin
         $display("tb_k_way_sorted_merge: done, clean");
      end else begin
         $display("tb_k_way_sorted_merge: done, errors");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("Timeout waiting for the run to finish.");
      $display("tb_k_way_sorted_merge: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/kwm_pkg.sv
rtl/core/kwm_elem_mem.sv
rtl/core/kwm_state_mem.sv
rtl/core/kwm_ctrl.sv
rtl/core/k_way_sorted_merge.sv
dv/tb_k_way_sorted_merge.sv
